FILE: hw/rtl/fed_pkg.sv
`default_nettype none

package fed_pkg;

  // Delay store geometry and sample format
  localparam int unsigned DEPTH       = 32768;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned SAMPLE_BITS = 16;

  // Register widths and reset values
  localparam int unsigned DELAY_W = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(16384);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);

  // Position within the buffer, saturating
  localparam int unsigned POS_W = 16;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(32768);

  // Q1.15 gain arithmetic
  localparam int unsigned FRAC  = 15;
  localparam int unsigned ACC_W = SAMPLE_BITS + GAIN_W + 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Per-beat control decided at accept time, used in the MAC stage
  typedef struct packed {
    logic active;     // echo term applies
    logic self_echo;  // zero delay: echo is the current input
    logic fwd;        // delay of one: echo is the previous result
  } s1_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fed_if.sv
`default_nettype none

interface fed_in_if;
  import fed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    buffer_start;

  modport source (output valid, output sample_in, output buffer_start, input ready);
  modport sink   (input valid, input sample_in, input buffer_start, output ready);
endinterface

interface fed_out_if;
  import fed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fed_ram.sv
`default_nettype none

module fed_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fed_mac.sv
`default_nettype none

module fed_mac (
  input  wire fed_pkg::s1_ctl_t     ctl_i,
  input  wire fed_pkg::sample_t     x_i,
  input  wire fed_pkg::sample_t     ram_echo_i,
  input  wire fed_pkg::sample_t     last_y_i,
  input  wire logic [fed_pkg::GAIN_W-1:0] gain_i,
  output fed_pkg::sample_t          y_o,
  output logic                      clip_o
);
  import fed_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  sample_t                 echo;
  logic signed [ACC_W-1:0] x_w;
  logic signed [ACC_W-1:0] g_w;
  logic signed [ACC_W-1:0] e_w;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;

  always_comb begin
    if (ctl_i.self_echo) begin
      echo = x_i;
    end else if (ctl_i.fwd) begin
      echo = last_y_i;
    end else begin
      echo = ram_echo_i;
    end

    x_w = ACC_W'(x_i);
    g_w = $signed(ACC_W'(gain_i));
    e_w = ACC_W'(echo);
    acc = (x_w <<< FRAC) + g_w * e_w + ROUND;
    q   = acc >>> FRAC;  // floor, so round half up overall

    y_o    = x_i;
    clip_o = 1'b0;
    if (ctl_i.active) begin
      if (q > SAT_MAX) begin
        y_o    = SAT_MAX[SAMPLE_BITS-1:0];
        clip_o = 1'b1;
      end else if (q < SAT_MIN) begin
        y_o    = SAT_MIN[SAMPLE_BITS-1:0];
        clip_o = 1'b1;
      end else begin
        y_o = q[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/feedback_echo_delay_core.sv
// Recursive echo for one audio channel (feedback comb filter).
//
// Input channel in_i: one beat per signed 16-bit sample; buffer_start marks
// the first sample of a buffer and restarts the position count at zero.
// Output channel out_o: one beat per input beat, in order, carrying the
// processed sample and a clipped flag when the rounded sum saturated.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i on the clock
// edge (0: delay_samples, 1: echo_gain in Q1.15). Write only while idle.
//
// Once a sample's position exceeds delay_samples, the output is x + gain *
// y[n - delay] (gain * x at zero delay), rounded half up and saturated.
//
// Throughput: one beat per cycle unless out_o stalls. Each beat does a
// single read of the delay RAM at accept time and a single write when it
// leaves the MAC stage; a delay of one is served from the last-result
// register. Accepted beats enter the MAC stage, then the output register.
// A stalled receiver fills the output register and then the MAC stage;
// in_i.ready drops only when both are full.
// Reset clears the pipeline, the write pointer, the position count and
// the registers to their defaults. The delay RAM is not cleared: every
// entry read was written earlier in the same buffer.
`default_nettype none

module feedback_echo_delay_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fed_in_if.sink                               in_i,
  fed_out_if.source                            out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fed_pkg::*;

  // Config registers
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;

  // Accept-side state
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  // MAC stage
  logic              s1_valid_q, s1_valid_d;
  s1_ctl_t           s1_ctl_q;
  sample_t           s1_x_q;
  logic [ADDR_W-1:0] s1_addr_q;
  sample_t           last_y_q;

  // Output register
  logic    out_valid_q, out_valid_d;
  sample_t out_y_q;
  logic    out_clip_q;

  // Combinational
  logic              in_fire;
  logic              s1_adv;
  logic              s1_move;
  logic [POS_W-1:0]  pos_eff;
  s1_ctl_t           ctl_new;
  logic [ADDR_W:0]   wp_ext;
  logic [ADDR_W:0]   d_ext;
  logic [ADDR_W:0]   rd_ext;
  logic [ADDR_W-1:0] rd_addr;
  sample_t           ram_rdata;
  sample_t           mac_y;
  logic              mac_clip;

  // Handshake: the MAC stage drains whenever the output register frees up
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign s1_move    = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  // Position, echo decision and read address for the incoming beat
  always_comb begin
    pos_eff = in_i.buffer_start ? '0 : pos_q;

    ctl_new.active    = (pos_eff > POS_W'(delay_q)) && (32'(delay_q) < DEPTH);
    ctl_new.self_echo = (delay_q == '0);
    ctl_new.fwd       = (delay_q == DELAY_W'(1));

    // Circular read of the result written delay_samples beats ago
    wp_ext = {1'b0, wp_q};
    d_ext  = (ADDR_W + 1)'(delay_q);
    if (wp_ext >= d_ext) begin
      rd_ext = wp_ext - d_ext;
    end else begin
      rd_ext = wp_ext + (ADDR_W + 1)'(DEPTH) - d_ext;
    end
    rd_addr = rd_ext[ADDR_W-1:0];
  end

  // Next-state for the accept side and pipeline valids
  always_comb begin
    wp_d        = wp_q;
    pos_d       = pos_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;

    if (in_fire) begin
      wp_d  = (wp_q == ADDR_W'(DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
      pos_d = (pos_eff == POS_LIMIT) ? pos_eff : pos_eff + POS_W'(1);
    end

    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Config writes
  always_comb begin
    delay_d = delay_q;
    gain_d  = gain_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELAY: delay_d = cfg_data_i[DELAY_W-1:0];
        REG_GAIN:  gain_d  = cfg_data_i[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= DELAY_RESET;
      gain_q      <= GAIN_RESET;
      wp_q        <= '0;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      delay_q     <= delay_d;
      gain_q      <= gain_d;
      wp_q        <= wp_d;
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q  <= ctl_new;
      s1_x_q    <= in_i.sample_in;
      s1_addr_q <= wp_q;
    end
    if (s1_move) begin
      last_y_q   <= mac_y;
      out_y_q    <= mac_y;
      out_clip_q <= mac_clip;
    end
  end

  // Delay store: read on accept, written as the beat leaves the MAC stage.
  // A delay of two or more always sees the write of its source beat.
  fed_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_addr_q),
    .wdata_i (mac_y),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  fed_mac u_mac (
    .ctl_i      (s1_ctl_q),
    .x_i        (s1_x_q),
    .ram_echo_i (ram_rdata),
    .last_y_i   (last_y_q),
    .gain_i     (gain_q),
    .y_o        (mac_y),
    .clip_o     (mac_clip)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_y_q;
  assign out_o.clipped    = out_clip_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fed_checker.sv
`default_nettype none

module fed_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic [fed_pkg::SAMPLE_BITS-1:0] out_sample_i,
  input wire logic                    out_clipped_i
);
  import fed_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Output beat is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i) && $stable(out_clipped_i))
    else $error("output payload changed while stalled");

  // With the output register empty the pipeline must be able to take a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // Saturation lands exactly on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_clipped_i |-> (out_sample_i == POS_FULL) || (out_sample_i == NEG_FULL))
    else $error("clipped beat not at a rail");

  // An accepted beat reaches the output via the MAC stage if unstalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> ##1 out_valid_i)
    else $error("output missing two cycles after accept");

endmodule

bind feedback_echo_delay_core fed_checker u_fed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_sample_i  (out_o.sample_out),
  .out_clipped_i (out_o.clipped)
);

`default_nettype wire

FILE: sim/tb_feedback_echo_delay_core.sv
`default_nettype none

module tb_feedback_echo_delay_core;
  import fed_pkg::*;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // Receiver behavior, switched between modes at random
  typedef enum logic [1:0] {
    RX_STREAM,   // always ready
    RX_RANDOM,   // ready about half the time
    RX_SPARSE    // ready about one cycle in four
  } rx_mode_e;

  typedef struct {
    sample_t sample;
    logic    start;
  } audio_beat_t;

  typedef struct {
    sample_t sample;
    logic    clipped;
  } echo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fed_in_if  in_if ();
  fed_out_if out_if ();

  feedback_echo_delay_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  // Beats waiting to be offered, and results the block still owes us
  audio_beat_t  pending_beats[$];
  echo_result_t expected_echo[$];

  int error_count  = 0;
  int results_seen = 0;

  // ---------------------------------------------------------------------------
  // Comb filter predictor: own copy of registers, delay line and counters.
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0] echo_delay = DELAY_RESET;
  logic [GAIN_W-1:0]  echo_gain  = GAIN_RESET;
  sample_t            echo_mem [DEPTH];
  logic [ADDR_W-1:0]  mem_wr_ptr = '0;
  logic [POS_W-1:0]   buf_pos    = '0;

  function automatic void predict_echo(sample_t x, logic start);
    longint            acc;
    longint            y;
    logic              clip;
    sample_t           echo;
    logic [ADDR_W-1:0] rd_addr;
    if (start) begin
      buf_pos = '0;
    end
    y    = longint'(x);
    clip = 1'b0;
    // Echo only once the position has passed the delay within this buffer
    if (buf_pos > POS_W'(echo_delay) && echo_delay < DEPTH) begin
      if (echo_delay == '0) begin
        echo = x;  // zero delay feeds the current input back on itself
      end else begin
        rd_addr = mem_wr_ptr - ADDR_W'(echo_delay);
        echo    = echo_mem[rd_addr];
      end
      acc = longint'(x) * 32768 + longint'(echo_gain) * longint'(echo) + 16384;
      y   = acc >>> FRAC;  // floor after +half: round half up
      if (y > SAMPLE_MAX) begin
        y    = SAMPLE_MAX;
        clip = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y    = SAMPLE_MIN;
        clip = 1'b1;
      end
    end
    echo_mem[mem_wr_ptr] = sample_t'(y);
    mem_wr_ptr           = mem_wr_ptr + 1'b1;
    if (buf_pos < POS_LIMIT) begin
      buf_pos = buf_pos + 1'b1;
    end
    expected_echo.push_back('{sample: sample_t'(y), clipped: clip});
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers beats from pending_beats in bursts with random gaps.
  // Acceptance is seen at the rising edge, new values go out at the falling.
  // ---------------------------------------------------------------------------
  logic beat_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_echo(in_if.sample_in, in_if.buffer_start);
      void'(pending_beats.pop_front());
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_if.valid        <= 1'b1;
        in_if.sample_in    <= pending_beats[0].sample;
        in_if.buffer_start <= pending_beats[0].start;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          // a quarter of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that is redrawn at random. Once,
  // after a few hundred results, it holds off long enough for the pipeline
  // to fill and back-pressure the input.
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode      = RX_STREAM;
  int       rx_mode_left = 0;
  int       hold_left    = 0;
  logic     hold_done    = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(8, 64);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_STREAM: begin
          out_if.ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every output beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    echo_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_echo.size() == 0) begin
        $error("sample_out: no result expected, got %0d", out_if.sample_out);
        error_count++;
      end else begin
        want = expected_echo.pop_front();
        if (out_if.sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, out_if.sample_out);
          error_count++;
        end
        if (out_if.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_if.clipped);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(sample_t s, logic start);
    pending_beats.push_back('{sample: s, start: start});
  endtask

  // Mix of full-scale noise, quiet signal and the rails
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2, 3:    return sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Wait until every beat went in and every result came out, then let the
  // pipeline settle before touching the registers.
  task automatic drain();
    while (pending_beats.size() != 0 || expected_echo.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [DELAY_W-1:0] d, logic [GAIN_W-1:0] g);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DELAY;
    cfg_data <= CFG_DATA_W'(d);
    @(negedge clk);
    cfg_idx  <= REG_GAIN;
    cfg_data <= g;
    @(negedge clk);
    cfg_we   <= 1'b0;
    echo_delay = d;
    echo_gain  = g;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [DELAY_W-1:0] d;
    logic [GAIN_W-1:0]  g;
    int                 n;
    int                 len;

    in_if.valid        = 1'b0;
    in_if.sample_in    = '0;
    in_if.buffer_start = 1'b0;
    out_if.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_DELAY;
    cfg_data           = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: position stays below the delay, so samples pass through
    queue_beat(sample_t'(SAMPLE_MAX), 1'b1);
    queue_beat(sample_t'(SAMPLE_MIN), 1'b0);
    queue_beat(sample_t'(0), 1'b0);
    queue_beat(sample_t'(-1), 1'b0);
    queue_beat(sample_t'(1), 1'b0);
    drain();

    // Zero delay at unity gain: the input echoes itself, both rails clip
    set_config('0, GAIN_W'(32768));
    queue_beat(sample_t'(100), 1'b1);
    queue_beat(sample_t'(SAMPLE_MAX), 1'b0);
    queue_beat(sample_t'(SAMPLE_MIN), 1'b0);
    queue_beat(sample_t'(-1), 1'b0);
    queue_beat(sample_t'(16385), 1'b0);
    queue_beat(sample_t'(3), 1'b0);
    drain();

    // Delay of one with gain near two; restart mid-stream drops the echo
    set_config(DELAY_W'(1), '1);
    queue_beat(sample_t'(20000), 1'b1);
    queue_beat(sample_t'(20000), 1'b0);
    queue_beat(sample_t'(-1), 1'b0);
    queue_beat(sample_t'(5), 1'b0);
    queue_beat(sample_t'(-7), 1'b1);
    queue_beat(sample_t'(9), 1'b0);
    drain();

    // Zero gain: echo term present but contributes nothing
    set_config(DELAY_W'(3), '0);
    queue_beat(sample_t'(1000), 1'b1);
    queue_beat(sample_t'(2), 1'b0);
    queue_beat(sample_t'(3), 1'b0);
    queue_beat(sample_t'(4), 1'b0);
    queue_beat(sample_t'(-5), 1'b0);
    queue_beat(sample_t'(6), 1'b0);
    drain();

    // Random phases: small delays, buffers mostly long enough to echo,
    // some shorter than the delay.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0:       d = '0;
        1:       d = DELAY_W'(1);
        2:       d = DELAY_W'(2);
        3:       d = DELAY_W'($urandom_range(3, 8));
        4:       d = DELAY_W'($urandom_range(9, 64));
        default: d = DELAY_W'($urandom_range(65, 128));
      endcase
      case ($urandom_range(0, 4))
        0:       g = '0;
        1:       g = GAIN_W'(32768);
        2:       g = '1;
        3:       g = GAIN_W'($urandom_range(0, 65535));
        default: g = GAIN_W'($urandom_range(0, 32768));
      endcase
      set_config(d, g);
      n = 0;
      while (n < 120) begin
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(1, int'(d) + 1);
        end else begin
          len = $urandom_range(int'(d) + 1, 2 * int'(d) + 24);
        end
        for (int k = 0; k < len; k++) begin
          queue_beat(rand_sample(), k == 0);
        end
        n += len;
      end
      drain();
    end

    // Longer delay in one buffer: the echo only starts past position 255
    set_config(DELAY_W'(255), GAIN_W'(32768));
    for (int k = 0; k < 300; k++) begin
      queue_beat(rand_sample(), k == 0);
    end
    drain();

    if (error_count == 0 && expected_echo.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
